// ===== hw/rtl/fpq_pkg.sv =====
// shared types and codes for the q24.8 fixed-point alu
package fpq_pkg;

  localparam int unsigned FracBitsDef = 8;

  typedef enum logic [4:0] {
    OP_ADD        = 5'd0,
    OP_SUB        = 5'd1,
    OP_MUL        = 5'd2,
    OP_DIV        = 5'd3,
    OP_LT         = 5'd4,
    OP_GT         = 5'd5,
    OP_LE         = 5'd6,
    OP_GE         = 5'd7,
    OP_EQ         = 5'd8,
    OP_NE         = 5'd9,
    OP_MIN        = 5'd10,
    OP_MAX        = 5'd11,
    OP_INC        = 5'd12,
    OP_DEC        = 5'd13,
    OP_FROM_INT   = 5'd14,
    OP_TO_INT     = 5'd15,
    OP_FROM_FLOAT = 5'd16,
    OP_TO_FLOAT   = 5'd17
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_INV  = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] val;
    logic [31:0] fout;
    logic        cmp;
    logic [1:0]  st;
  } res_t;

endpackage

// ===== hw/rtl/fixed_point_q24_8_alu_top.sv =====
// Pipelined signed fixed-point alu (Q24.8 by default): add, sub, mul, div, compares,
// min/max, inc/dec and int/float conversions. One word is taken every cycle while the
// output side does not stall; every operation passes through the divider stages. The
// divider retires one quotient bit per stage over 32 + FRACTION_BITS stages. A stall at
// the output freezes the whole pipeline.
module fixed_point_q24_8_alu_top #(
  parameter int unsigned FRACTION_BITS = fpq_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [4:0]         kind_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  input  logic signed [31:0] int_in_i,
  input  logic [31:0]        float_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_out_o,
  output logic [31:0]        float_out_o,
  output logic               compare_true_o,
  output logic [1:0]         status_o
);
  import fpq_pkg::*;

  localparam int unsigned QW = 32 + FRACTION_BITS;

  typedef struct packed {
    logic [4:0]         op;
    res_t               res;
    logic signed [63:0] prod;
    logic [31:0]        fmag;
    logic [4:0]         fp;
    logic               fsign;
    logic               is_div;
    logic               qneg;
    logic [31:0]        maga;
    logic [31:0]        magb;
  } s1_t;

  typedef struct packed {
    res_t          res;
    logic          is_div;
    logic          qneg;
    logic [31:0]   rem;
    logic [QW-1:0] dq;
    logic [31:0]   dvsr;
  } div_t;

  logic adv;
  logic s1_v_q;
  s1_t  s1_d, s1_q;
  logic [QW:0] dvv_q;
  div_t dv_q [QW+1];
  div_t dv0_d;
  div_t dv_nx [QW];
  logic out_v_q;
  res_t out_d, out_q;

  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage 1 signals
  logic signed [32:0] sum_w, dif_w, inc_w, dec_w;
  logic [QW-1:0]      fi_w;
  logic [FRACTION_BITS:0] fi_hi;
  logic [7:0]  fe;
  logic [23:0] m24;
  logic signed [9:0] fs;
  logic [9:0]  shr;
  logic [25:0] rnd26;
  logic [63:0] ff_mag, ff_lim;
  logic        ff_big, ff_sat, fneg;
  logic [31:0] ff_val;

  always_comb begin
    sum_w = {operand_a_i[31], operand_a_i} + {operand_b_i[31], operand_b_i};
    dif_w = {operand_a_i[31], operand_a_i} - {operand_b_i[31], operand_b_i};
    inc_w = {operand_a_i[31], operand_a_i} + 33'd1;
    dec_w = {operand_a_i[31], operand_a_i} - 33'd1;
    fi_w  = {int_in_i, {FRACTION_BITS{1'b0}}};
    fi_hi = fi_w[QW-1:31];

    // float to fixed, half away from zero
    fneg   = float_in_i[31];
    fe     = float_in_i[30:23];
    m24    = {(fe != 8'd0), float_in_i[22:0]};
    fs     = $signed({2'b00, (fe == 8'd0) ? 8'd1 : fe}) - 10'sd150
             + $signed(10'(FRACTION_BITS));
    shr    = 10'(-fs);
    rnd26  = '0;
    ff_big = 1'b0;
    if (fs >= 10'sd0) begin
      ff_big = fs > 10'sd39;
      ff_mag = 64'(m24) << fs[5:0];
    end else if (shr > 10'd25) begin
      ff_mag = '0;
    end else begin
      rnd26  = {2'b00, m24} + (26'd1 << (shr[4:0] - 5'd1));
      ff_mag = 64'(rnd26 >> shr[4:0]);
    end
    ff_lim = fneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    ff_sat = (fe == 8'hFF) || ((m24 != 24'd0) && (ff_big || ff_mag > ff_lim));
    if (ff_sat) begin
      ff_val = fneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (m24 == 24'd0) begin
      ff_val = '0;
    end else begin
      ff_val = fneg ? (32'd0 - ff_mag[31:0]) : ff_mag[31:0];
    end

    s1_d        = '0;
    s1_d.op     = kind_i;
    s1_d.prod   = 64'(operand_a_i) * 64'(operand_b_i);
    s1_d.fsign  = operand_a_i[31];
    s1_d.fmag   = operand_a_i[31] ? (32'd0 - operand_a_i) : operand_a_i;
    for (int i = 0; i < 32; i++) begin
      if (s1_d.fmag[i]) s1_d.fp = 5'(i);
    end
    s1_d.qneg   = operand_a_i[31] ^ operand_b_i[31];
    s1_d.maga   = s1_d.fmag;
    s1_d.magb   = operand_b_i[31] ? (32'd0 - operand_b_i) : operand_b_i;

    case (kind_i)
      OP_ADD: begin
        s1_d.res.val = sum_w[31:0];
        s1_d.res.st  = (sum_w[32] != sum_w[31]) ? ST_OVF : ST_OK;
      end
      OP_SUB: begin
        s1_d.res.val = dif_w[31:0];
        s1_d.res.st  = (dif_w[32] != dif_w[31]) ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (operand_b_i == 32'sd0) s1_d.res.st = ST_DIVZ;
        else                       s1_d.is_div = 1'b1;
      end
      OP_LT:  s1_d.res.cmp = operand_a_i <  operand_b_i;
      OP_GT:  s1_d.res.cmp = operand_a_i >  operand_b_i;
      OP_LE:  s1_d.res.cmp = operand_a_i <= operand_b_i;
      OP_GE:  s1_d.res.cmp = operand_a_i >= operand_b_i;
      OP_EQ:  s1_d.res.cmp = operand_a_i == operand_b_i;
      OP_NE:  s1_d.res.cmp = operand_a_i != operand_b_i;
      OP_MIN: s1_d.res.val = (operand_a_i <= operand_b_i) ? operand_a_i : operand_b_i;
      OP_MAX: s1_d.res.val = (operand_a_i >= operand_b_i) ? operand_a_i : operand_b_i;
      OP_INC: begin
        s1_d.res.val = inc_w[31:0];
        s1_d.res.st  = (inc_w[32] != inc_w[31]) ? ST_OVF : ST_OK;
      end
      OP_DEC: begin
        s1_d.res.val = dec_w[31:0];
        s1_d.res.st  = (dec_w[32] != dec_w[31]) ? ST_OVF : ST_OK;
      end
      OP_FROM_INT: begin
        s1_d.res.val = fi_w[31:0];
        s1_d.res.st  = ((&fi_hi) || (~|fi_hi)) ? ST_OK : ST_OVF;
      end
      OP_TO_INT:     s1_d.res.val = 32'(operand_a_i >>> FRACTION_BITS);
      OP_FROM_FLOAT: begin
        s1_d.res.val = ff_val;
        s1_d.res.st  = ff_sat ? ST_INV : ST_OK;
      end
      default: ;
    endcase
  end

  // stage 2: finish multiply and to-float, load the divider
  logic signed [63:0] mq;
  logic [32:0]  mq_hi;
  logic [31:0]  norm;
  logic         rbit;
  logic [24:0]  k25;
  logic [5:0]   pe;
  logic [8:0]   fexp;

  always_comb begin
    mq    = s1_q.prod >>> FRACTION_BITS;
    mq_hi = mq[63:31];
    norm  = s1_q.fmag << (~s1_q.fp);
    rbit  = norm[7] && ((|norm[6:0]) || norm[8]);
    k25   = {1'b0, norm[31:8]} + 25'(rbit);
    pe    = k25[24] ? (6'(s1_q.fp) + 6'd1) : 6'(s1_q.fp);
    fexp  = 9'(pe) + 9'd127 - 9'(FRACTION_BITS);

    dv0_d        = '0;
    dv0_d.res    = s1_q.res;
    dv0_d.is_div = s1_q.is_div;
    dv0_d.qneg   = s1_q.qneg;
    dv0_d.dq     = {s1_q.maga, {FRACTION_BITS{1'b0}}};
    dv0_d.dvsr   = s1_q.magb;
    if (s1_q.op == OP_MUL) begin
      dv0_d.res.val = mq[31:0];
      dv0_d.res.st  = ((&mq_hi) || (~|mq_hi)) ? ST_OK : ST_OVF;
    end
    if (s1_q.op == OP_TO_FLOAT && s1_q.fmag != 32'd0) begin
      dv0_d.res.fout = {s1_q.fsign, fexp[7:0], k25[24] ? 23'd0 : k25[22:0]};
    end
  end

  // one restoring quotient bit per stage
  logic [32:0] t;
  logic        ge;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      dv_nx[k] = dv_q[k];
      t  = {dv_q[k].rem, dv_q[k].dq[QW-1]};
      ge = t >= {1'b0, dv_q[k].dvsr};
      dv_nx[k].rem = ge ? 32'(t - {1'b0, dv_q[k].dvsr}) : t[31:0];
      dv_nx[k].dq  = {dv_q[k].dq[QW-2:0], ge};
    end
  end

  logic [QW-1:0] quo;
  logic          q_fit;

  always_comb begin
    quo   = dv_q[QW].dq;
    out_d = dv_q[QW].res;
    if (dv_q[QW].qneg) begin
      q_fit = (quo[QW-1:32] == '0) && (!quo[31] || (quo[30:0] == 31'd0));
    end else begin
      q_fit = (quo[QW-1:31] == '0);
    end
    if (dv_q[QW].is_div) begin
      out_d.val = dv_q[QW].qneg ? (32'd0 - quo[31:0]) : quo[31:0];
      out_d.st  = q_fit ? ST_OK : ST_OVF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      dvv_q   <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= in_valid_i;
      dvv_q   <= {dvv_q[QW-1:0], s1_v_q};
      out_v_q <= dvv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s1_d;
      dv_q[0]  <= dv0_d;
      for (int k = 0; k < QW; k++) begin
        dv_q[k+1] <= dv_nx[k];
      end
      out_q    <= out_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign value_out_o    = out_q.val;
  assign float_out_o    = out_q.fout;
  assign compare_true_o = out_q.cmp;
  assign status_o       = out_q.st;

endmodule

// ===== hw/rtl/fpq_chk.sv =====
// port-level checks for the fixed-point alu, bound to the top level
module fpq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_out_o,
  input logic [31:0] float_out_o,
  input logic        compare_true_o,
  input logic [1:0]  status_o
);
  import fpq_pkg::*;

  // a held word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_backpress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> value_out_o == 32'd0 && float_out_o == 32'd0
      && status_o == ST_OK)
    else $error("compare result with other fields set");

  a_float: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && float_out_o != 32'd0 |-> value_out_o == 32'd0 && status_o == ST_OK)
    else $error("float result with value or status set");

  a_divz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DIVZ |-> value_out_o == 32'd0 && !compare_true_o)
    else $error("divide by zero with non-zero value");

endmodule

bind fixed_point_q24_8_alu_top fpq_chk u_fpq_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .value_out_o    (value_out_o),
  .float_out_o    (float_out_o),
  .compare_true_o (compare_true_o),
  .status_o       (status_o)
);

// ===== bench/testbench.sv =====
// self-checking testbench for the q24.8 fixed-point alu
`timescale 1ns / 100ps

module testbench;
  import fpq_pkg::*;

  localparam int unsigned FracBits = 8;
  localparam int unsigned Latency = FracBits + 35;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomWords = 1350;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] iv;
    logic [31:0] fin;
  } alu_word_t;

  typedef struct packed {
    logic        given;
    logic [31:0] val;
    logic [31:0] fout;
    logic        cmp;
    logic [1:0]  st;
  } typed_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [4:0]         kind_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic signed [31:0] int_in_i = '0;
  logic [31:0]        float_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] value_out_o;
  logic [31:0]        float_out_o;
  logic               compare_true_o;
  logic [1:0]         status_o;

  fixed_point_q24_8_alu_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  res_t       pending_results[$];
  alu_word_t  directed_words[$];
  typed_res_t directed_results[$];
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;

  function automatic logic [31:0] wrap32(input logic signed [63:0] v, inout logic [1:0] st);
    if (v > 64'sd2147483647 || v < -64'sd2147483648) st = ST_OVF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] float_to_q(input logic [31:0] f, inout logic [1:0] st);
    logic            neg;
    logic [7:0]      e;
    logic [63:0]     m, mag, lim;
    int              s;
    neg = f[31];
    e = f[30:23];
    m = {41'd0, f[22:0]};
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (e == 8'hFF) begin
      st = ST_INV;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (e == 8'd0) begin
      s = 1 - 150 + FracBits;
    end else begin
      m[23] = 1'b1;
      s = int'(e) - 150 + FracBits;
    end
    if (m == '0) return '0;
    if (s >= 0) begin
      if (s > 39) begin
        st = ST_INV;
        return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      mag = m << s;
    end else if (-s > 25) begin
      mag = '0;
    end else begin
      mag = (m + (64'd1 << (-s - 1))) >> (-s);
    end
    if (mag > lim) begin
      st = ST_INV;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return neg ? (~mag[31:0] + 32'd1) : mag[31:0];
  endfunction

  function automatic logic [31:0] q_to_float(input logic signed [31:0] a);
    logic [31:0] mag, keep, rem, half;
    int          p, sh;
    mag = a[31] ? (~a + 32'd1) : a;
    if (mag == '0) return '0;
    p = 31;
    while (mag[p] == 1'b0) p--;
    if (p <= 23) begin
      keep = mag << (23 - p);
    end else begin
      sh = p - 23;
      rem = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == 32'h0100_0000) begin
        keep >>= 1;
        p++;
      end
    end
    return {a[31], 8'(p - FracBits + 127), keep[22:0]};
  endfunction

  function automatic res_t alu_result(input alu_word_t w);
    res_t               r;
    logic signed [63:0] a, b, iv, prod;
    logic [1:0]         st;
    a = 64'(signed'(w.a));
    b = 64'(signed'(w.b));
    iv = 64'(signed'(w.iv));
    st = ST_OK;
    r = '0;
    case (w.kind)
      OP_ADD: r.val = wrap32(a + b, st);
      OP_SUB: r.val = wrap32(a - b, st);
      OP_MUL: begin
        prod = a * b;
        r.val = wrap32(prod >>> FracBits, st);
      end
      OP_DIV: begin
        if (b == 0) st = ST_DIVZ;
        else r.val = wrap32((a <<< FracBits) / b, st);
      end
      OP_LT: r.cmp = a < b;
      OP_GT: r.cmp = a > b;
      OP_LE: r.cmp = a <= b;
      OP_GE: r.cmp = a >= b;
      OP_EQ: r.cmp = a == b;
      OP_NE: r.cmp = a != b;
      OP_MIN: r.val = (a <= b) ? w.a : w.b;
      OP_MAX: r.val = (a >= b) ? w.a : w.b;
      OP_INC: r.val = wrap32(a + 1, st);
      OP_DEC: r.val = wrap32(a - 1, st);
      OP_FROM_INT: r.val = wrap32(iv <<< FracBits, st);
      OP_TO_INT: r.val = wrap32(a >>> FracBits, st);
      OP_FROM_FLOAT: r.val = float_to_q(w.fin, st);
      OP_TO_FLOAT: r.fout = q_to_float(w.a);
      default: ;
    endcase
    r.st = st;
    return r;
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'(signed'($urandom_range(0, 2048)) - 1024);
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                      : 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_float();
    logic [31:0] f;
    f = $urandom;
    if ($urandom_range(0, 3) != 0) f[30:23] = 8'($urandom_range(100, 165));
    else if ($urandom_range(0, 1)) f[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return f;
  endfunction

  task automatic add_row(input op_e k, input logic [31:0] a, input logic [31:0] b,
                         input logic [31:0] iv, input logic [31:0] fin,
                         input int given = 0, input logic [31:0] val = '0,
                         input logic [31:0] fout = '0, input int cmp = 0,
                         input status_e st = ST_OK);
    directed_words.push_back({k, a, b, iv, fin});
    directed_results.push_back({given[0], val, fout, cmp[0], st});
  endtask

  task automatic send_word(input alu_word_t w);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= w.kind;
    operand_a_i <= w.a;
    operand_b_i <= w.b;
    int_in_i    <= w.iv;
    float_in_i  <= w.fin;
    pending_results.push_back(alu_result(w));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // drive the stall side independently
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 31);
  end

  // compare each accepted result word
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending");
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (value_out_o !== e.val) begin
          $error("value_out expected %h got %h", e.val, value_out_o);
          failures++;
        end
        if (float_out_o !== e.fout) begin
          $error("float_out expected %h got %h", e.fout, float_out_o);
          failures++;
        end
        if (compare_true_o !== e.cmp) begin
          $error("compare_true expected %b got %b", e.cmp, compare_true_o);
          failures++;
        end
        if (status_o !== e.st) begin
          $error("status expected %0d got %0d", e.st, status_o);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    alu_word_t w;
    res_t      r;
    int        wait_cycles;
    add_row(OP_ADD, 32'h7FFF_FFFF, 32'h1, '0, '0, 1, 32'h8000_0000, 0, 0, ST_OVF);
    add_row(OP_SUB, 32'h8000_0000, 32'h1, '0, '0, 1, 32'h7FFF_FFFF, 0, 0, ST_OVF);
    add_row(OP_MUL, 32'hFFFF_FF80, 32'h0000_0180, '0, '0);
    add_row(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0);
    add_row(OP_DIV, 32'h100, 32'h0, '0, '0, 1, 0, 0, 0, ST_DIVZ);
    add_row(OP_DIV, 32'h8000_0000, 32'hFFFF_FF00, '0, '0);
    add_row(OP_DIV, 32'hFFFF_FD00, 32'h200, '0, '0);
    add_row(OP_LT, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 1, 0, 0, 1, ST_OK);
    add_row(OP_GT, 32'h5, 32'h5, '0, '0, 1, 0, 0, 0, ST_OK);
    add_row(OP_LE, 32'h5, 32'h5, '0, '0, 1, 0, 0, 1, ST_OK);
    add_row(OP_GE, 32'hFFFF_FFFF, 32'h0, '0, '0, 1, 0, 0, 0, ST_OK);
    add_row(OP_EQ, 32'h8000_0000, 32'h8000_0000, '0, '0, 1, 0, 0, 1, ST_OK);
    add_row(OP_NE, 32'h1, 32'h1, '0, '0, 1, 0, 0, 0, ST_OK);
    add_row(OP_MIN, 32'h7, 32'h7, '0, '0, 1, 32'h7, 0, 0, ST_OK);
    add_row(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 1, 32'h7FFF_FFFF, 0, 0, ST_OK);
    add_row(OP_INC, 32'h7FFF_FFFF, '0, '0, '0, 1, 32'h8000_0000, 0, 0, ST_OVF);
    add_row(OP_DEC, 32'h8000_0000, '0, '0, '0, 1, 32'h7FFF_FFFF, 0, 0, ST_OVF);
    add_row(OP_FROM_INT, '0, '0, 32'h0080_0000, '0, 1, 32'h8000_0000, 0, 0, ST_OVF);
    add_row(OP_TO_INT, 32'hFFFF_FF01, '0, '0, '0, 1, 32'hFFFF_FFFF, 0, 0, ST_OK);
    add_row(OP_FROM_FLOAT, '0, '0, '0, 32'h7F80_0000, 1, 32'h7FFF_FFFF, 0, 0, ST_INV);
    add_row(OP_FROM_FLOAT, '0, '0, '0, 32'hFFC0_0001, 1, 32'h8000_0000, 0, 0, ST_INV);
    add_row(OP_FROM_FLOAT, '0, '0, '0, 32'h8000_0000, 1, 32'h0, 0, 0, ST_OK);
    add_row(OP_FROM_FLOAT, '0, '0, '0, 32'h3B80_0000);
    add_row(OP_TO_FLOAT, 32'h0, '0, '0, '0, 1, 0, 0, 0, ST_OK);
    add_row(OP_TO_FLOAT, 32'h8000_0000, '0, '0, '0);
    add_row(op_e'(5'd31), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1, 0, 0, 0, ST_OK);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_words[i]) begin
      r = alu_result(directed_words[i]);
      if (directed_results[i].given &&
          {r.val, r.fout, r.cmp, r.st} !== {directed_results[i].val, directed_results[i].fout,
                                             directed_results[i].cmp, directed_results[i].st})
      begin
        $error("directed row %0d disagrees with the predictor", i);
        failures++;
      end
      send_word(directed_words[i]);
    end

    for (int n = 0; n < RandomWords; n++) begin
      calm = (n >= 500 && n < 700);
      w.kind = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                           : 5'($urandom_range(0, 17));
      w.a = pick32();
      w.b = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? w.a : 32'h0) : pick32();
      w.iv = pick32();
      w.fin = pick_float();
      send_word(w);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 10) @(posedge clk_i);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
